/* rtl/keyed_record_list_engine_macros.svh */
// ----------------------------------------------------------------------------
// keyed record list engine assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_LIST_ENGINE_MACROS_SVH
`define KEYED_RECORD_LIST_ENGINE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define KLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kle_pkg.sv */
// ----------------------------------------------------------------------------
// kle_pkg
// types, codes and sizes shared by the keyed record list engine
// ----------------------------------------------------------------------------
package kle_pkg;

  // number of record cells in the row
  localparam int CAPACITY = 32;
  // width of a 0-based cell index
  localparam int IDX_W = $clog2(CAPACITY);
  // width of the record count, which can reach CAPACITY
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // width that holds both a position field and the count, plus one
  localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef struct packed {
    logic [63:0] key_low;
    logic [7:0]  key_high;
    logic [7:0]  score_a;
    logic [7:0]  score_b;
    logic [7:0]  score_c;
  } rec_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_FROM_LOWER = 2'd2,
    OP_FROM_UPPER = 2'd3
  } cell_op_t;

  // per-cell control from the sequencer
  typedef struct packed {
    cell_op_t op;
    logic     valid;
  } cell_ctl_t;

endpackage

/* rtl/kle_cell.sv */
// ----------------------------------------------------------------------------
// kle_cell
// one record slot: holds a record, compares its key, moves to a neighbor
// ----------------------------------------------------------------------------
module kle_cell (
  input  logic              clk,
  input  kle_pkg::cell_ctl_t ctl,
  input  kle_pkg::rec_t     new_rec,
  input  kle_pkg::rec_t     lower_rec,
  input  kle_pkg::rec_t     upper_rec,
  input  logic [63:0]       key_low,
  input  logic [7:0]        key_high,
  output kle_pkg::rec_t     rec,
  output logic              match
);

  // record storage, shifted or loaded under sequencer control
  always_ff @(posedge clk) begin
    case (ctl.op)
      kle_pkg::OP_LOAD:       rec <= new_rec;
      kle_pkg::OP_FROM_LOWER: rec <= lower_rec;
      kle_pkg::OP_FROM_UPPER: rec <= upper_rec;
      default: ;
    endcase
  end

  // full 9-byte key compare, only for occupied slots
  assign match = ctl.valid && (rec.key_low == key_low) && (rec.key_high == key_high);

endmodule

/* rtl/keyed_record_list_engine.sv */
// ----------------------------------------------------------------------------
// keyed_record_list_engine
// ordered list of keyed records held in a row of shifting cells
// ----------------------------------------------------------------------------
// Every command runs in order: the start beat is taken while idle, after
// which busy is high for one execute cycle; in the cycle after that done
// strobes the result and start is already accepted again. The execute cycle
// is where every cell of the row compares its key and moves its record one
// place up or down at once, so a command takes the same time whatever the
// list length. Results are shown for one cycle only and must be taken then.
// Reset empties the list by clearing the record count; record contents need
// no clearing.
// ----------------------------------------------------------------------------
module keyed_record_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [5:0]  position,
  input  logic [63:0] key_low,
  input  logic [7:0]  key_high,
  input  logic [7:0]  score_a,
  input  logic [7:0]  score_b,
  input  logic [7:0]  score_c,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  found_position,
  output logic [63:0] out_key_low,
  output logic [7:0]  out_key_high,
  output logic [7:0]  out_score_a,
  output logic [7:0]  out_score_b,
  output logic [7:0]  out_score_c,
  output logic [5:0]  list_length
);

  localparam int CAP   = kle_pkg::CAPACITY;
  localparam int IDX_W = kle_pkg::IDX_W;
  localparam int CNT_W = kle_pkg::CNT_W;
  localparam int CMP_W = kle_pkg::CMP_W;

  kle_pkg::state_t   state, state_next;
  kle_pkg::cmd_t     cmd_q;
  logic [5:0]        pos_q;
  kle_pkg::rec_t     in_rec;
  logic [CNT_W-1:0]  count, count_next;
  logic              done_next;

  kle_pkg::rec_t     cell_rec [CAP];
  kle_pkg::cell_ctl_t cell_ctl [CAP];
  logic [CAP-1:0]    match;
  logic [CAP-1:0]    first_hit;
  logic [CAP-1:0]    sel;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  pos_idx;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [IDX_W:0]    hit_pos;
  logic              any_hit;
  logic              do_insert;
  logic              do_delete;
  logic              echo_new;
  kle_pkg::status_t  status_next;
  logic [5:0]        fpos_next;
  kle_pkg::rec_t     emit_rec;
  kle_pkg::rec_t     emit_next;
  logic              accept;

  assign accept = start && !busy;
  assign busy   = (state == kle_pkg::S_EXEC);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kle_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= kle_pkg::cmd_t'(command);
      pos_q  <= position;
      in_rec <= '{key_low: key_low, key_high: key_high,
                  score_a: score_a, score_b: score_b, score_c: score_c};
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == kle_pkg::S_EXEC) begin
      status         <= status_next;
      found_position <= fpos_next;
      out_key_low    <= emit_next.key_low;
      out_key_high   <= emit_next.key_high;
      out_score_a    <= emit_next.score_a;
      out_score_b    <= emit_next.score_b;
      out_score_c    <= emit_next.score_c;
    end
  end

  assign list_length = 6'(count);

  // first match among occupied cells, one-hot then encoded
  always_comb begin
    first_hit = match & (~match + {{(CAP-1){1'b0}}, 1'b1});
    any_hit   = |match;
    hit_idx   = '0;
    for (int i = 0; i < CAP; i++) begin
      if (first_hit[i]) hit_idx = hit_idx | IDX_W'(i);
    end
    hit_pos = {1'b0, hit_idx} + {{IDX_W{1'b0}}, 1'b1};
  end

  // command decode, status and cell moves
  always_comb begin
    state_next  = state;
    count_next  = count;
    done_next   = 1'b0;
    status_next = kle_pkg::ST_OK;
    fpos_next   = '0;
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    echo_new    = 1'b0;
    sel         = '0;
    pos_ext     = CMP_W'(pos_q);
    cnt_ext     = CMP_W'(count);
    pos_idx     = IDX_W'(pos_q - 6'd1);

    case (state)
      kle_pkg::S_IDLE: begin
        if (accept) state_next = kle_pkg::S_EXEC;
      end
      kle_pkg::S_EXEC: begin
        state_next = kle_pkg::S_IDLE;
        done_next  = 1'b1;
        case (cmd_q)
          kle_pkg::CMD_INSERT: begin
            if (count >= CNT_W'(CAP)) begin
              status_next = kle_pkg::ST_FULL;
            end else if (pos_q == 6'd0 || pos_ext > cnt_ext + CMP_W'(1)) begin
              status_next = kle_pkg::ST_RANGE;
            end else begin
              do_insert  = 1'b1;
              echo_new   = 1'b1;
              fpos_next  = pos_q;
              count_next = count + CNT_W'(1);
            end
          end
          kle_pkg::CMD_READ: begin
            if (pos_q == 6'd0 || pos_ext > cnt_ext) begin
              status_next = kle_pkg::ST_RANGE;
            end else begin
              fpos_next = pos_q;
              for (int i = 0; i < CAP; i++) begin
                sel[i] = (IDX_W'(i) == pos_idx);
              end
            end
          end
          default: begin
            if (!any_hit) begin
              status_next = kle_pkg::ST_NOT_FOUND;
            end else begin
              fpos_next = 6'(hit_pos);
              sel       = first_hit;
              if (cmd_q == kle_pkg::CMD_DELETE) begin
                do_delete  = 1'b1;
                count_next = count - CNT_W'(1);
              end
            end
          end
        endcase
      end
      default: state_next = kle_pkg::S_IDLE;
    endcase
  end

  // per-cell moves: open a gap on insert, close it on delete
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      cell_ctl[i].valid = (CNT_W'(i) < count);
      cell_ctl[i].op    = kle_pkg::OP_HOLD;
      if (do_insert) begin
        if (IDX_W'(i) == pos_idx) cell_ctl[i].op = kle_pkg::OP_LOAD;
        else if (IDX_W'(i) > pos_idx) cell_ctl[i].op = kle_pkg::OP_FROM_LOWER;
      end else if (do_delete) begin
        if (IDX_W'(i) >= hit_idx) cell_ctl[i].op = kle_pkg::OP_FROM_UPPER;
      end
    end
  end

  // returned record: selected cell, or the new record on insert
  always_comb begin
    emit_rec = '0;
    for (int i = 0; i < CAP; i++) begin
      if (sel[i]) emit_rec = emit_rec | cell_rec[i];
    end
    emit_next = echo_new ? in_rec : emit_rec;
  end

  // row of record cells
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    kle_pkg::rec_t lower_rec;
    kle_pkg::rec_t upper_rec;

    if (g == 0) begin : g_first
      assign lower_rec = in_rec;
    end else begin : g_mid_lo
      assign lower_rec = cell_rec[g-1];
    end

    if (g == CAP - 1) begin : g_last
      assign upper_rec = cell_rec[g];
    end else begin : g_mid_hi
      assign upper_rec = cell_rec[g+1];
    end

    kle_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .new_rec   (in_rec),
      .lower_rec (lower_rec),
      .upper_rec (upper_rec),
      .key_low   (in_rec.key_low),
      .key_high  (in_rec.key_high),
      .rec       (cell_rec[g]),
      .match     (match[g])
    );
  end

endmodule

/* rtl/kle_checker.sv */
// ----------------------------------------------------------------------------
// kle_checker
// port-level checks of the keyed record list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "keyed_record_list_engine_macros.svh"

module kle_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [5:0]  found_position,
  input logic [63:0] out_key_low,
  input logic [5:0]  list_length
);

  // a start beat leads to exactly one execute cycle
  `KLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not go busy")

  // execute cycle always ends in a result beat
  `KLE_ASSERT_NEXT(a_busy_done, busy, done && !busy, "busy did not end in a result")

  // an error beat carries no record
  `KLE_ASSERT_NOW(a_err_empty, done && (status != kle_pkg::ST_OK),
    (found_position == 6'd0) && (out_key_low == 64'd0), "error result carries data")

  // list never grows past capacity
  `KLE_ASSERT_NOW(a_len_cap, done, 32'(list_length) <= kle_pkg::CAPACITY,
    "list length above capacity")

endmodule

bind keyed_record_list_engine kle_checker u_kle_checker (.*);

/* tb/keyed_record_list_engine_tb.sv */
// ----------------------------------------------------------------------------
// keyed_record_list_engine_tb
// drives insert, read, find and delete commands into the record list engine
// and checks every result against a software copy of the list. A directed
// opening covers the edge cases, then random phases grow the list until it
// is full and shrink it until it is empty, with and without sender gaps.
// ----------------------------------------------------------------------------
module keyed_record_list_engine_tb;
  import kle_pkg::*;

  // one result beat as seen on the result ports
  typedef struct packed {
    status_t     status;
    logic [5:0]  found_at;
    rec_t        rec;
    logic [5:0]  length;
  } reply_t;

  // software copy of the list and the queue of results still owed
  class record_list_tracker;
    rec_t   cells[CAPACITY];
    int     count;
    reply_t pending_replies[$];
    int     errors;
    int     peak_length;
    int     cmd_seen[4];
    int     status_seen[4];

    // work out the result of an accepted command and update the list
    function void note_command(cmd_t cmd, logic [5:0] pos, rec_t rec);
      reply_t want;
      int     p;
      int     idx;
      want = '0;
      p = int'(pos);
      idx = -1;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_INSERT: begin
          if (count >= CAPACITY) begin
            want.status = ST_FULL;
          end else if (p < 1 || p > count + 1) begin
            want.status = ST_RANGE;
          end else begin
            for (int j = count; j > p - 1; j--) cells[j] = cells[j - 1];
            cells[p - 1] = rec;
            count++;
            want.found_at = pos;
            want.rec = rec;
          end
        end
        CMD_READ: begin
          if (p < 1 || p > count) begin
            want.status = ST_RANGE;
          end else begin
            want.found_at = pos;
            want.rec = cells[p - 1];
          end
        end
        default: begin
          // first record whose whole nine-byte key matches
          for (int j = 0; j < count; j++)
            if (idx < 0 && cells[j].key_low == rec.key_low &&
                cells[j].key_high == rec.key_high) idx = j;
          if (idx < 0) begin
            want.status = ST_NOT_FOUND;
          end else begin
            want.found_at = 6'(idx + 1);
            want.rec = cells[idx];
            if (cmd == CMD_DELETE) begin
              for (int j = idx; j + 1 < count; j++) cells[j] = cells[j + 1];
              count--;
            end
          end
        end
      endcase
      want.length = 6'(count);
      status_seen[want.status]++;
      if (count > peak_length) peak_length = count;
      pending_replies.push_back(want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        errors++;
        // keep the log short when the block is badly off
        if (errors <= 50)
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
      end
    endfunction

    // compare one result beat with the oldest outstanding one
    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: result beat with no command outstanding", $time);
        return;
      end
      want = pending_replies.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("found_position", 64'(want.found_at), 64'(got.found_at));
      compare_field("out_key_low", want.rec.key_low, got.rec.key_low);
      compare_field("out_key_high", 64'(want.rec.key_high), 64'(got.rec.key_high));
      compare_field("out_score_a", 64'(want.rec.score_a), 64'(got.rec.score_a));
      compare_field("out_score_b", 64'(want.rec.score_b), 64'(got.rec.score_b));
      compare_field("out_score_c", 64'(want.rec.score_c), 64'(got.rec.score_c));
      compare_field("list_length", 64'(want.length), 64'(got.length));
    endfunction

    function void close_out();
      if (pending_replies.size() != 0) begin
        errors += pending_replies.size();
        $display("%0t: %0d results never arrived", $time, pending_replies.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_READ;
  logic [5:0]  position = '0;
  logic [63:0] key_low = '0;
  logic [7:0]  key_high = '0;
  logic [7:0]  score_a = '0;
  logic [7:0]  score_b = '0;
  logic [7:0]  score_c = '0;
  logic        done;
  logic [1:0]  status;
  logic [5:0]  found_position;
  logic [63:0] out_key_low;
  logic [7:0]  out_key_high;
  logic [7:0]  out_score_a;
  logic [7:0]  out_score_b;
  logic [7:0]  out_score_c;
  logic [5:0]  list_length;

  record_list_tracker tracker = new();

  // small pool of names; odd entries share key_low with the one before
  logic [63:0] name_low[8];
  logic [7:0]  name_high[8];
  bit          shrinking;

  always #6 clk = ~clk;

  keyed_record_list_engine DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .position(position), .key_low(key_low),
    .key_high(key_high), .score_a(score_a), .score_b(score_b),
    .score_c(score_c), .done(done), .status(status),
    .found_position(found_position), .out_key_low(out_key_low),
    .out_key_high(out_key_high), .out_score_a(out_score_a),
    .out_score_b(out_score_b), .out_score_c(out_score_c),
    .list_length(list_length)
  );

  // check result beats first, then note a command beat taken at this edge
  always @(posedge clk) begin
    reply_t got;
    if (!rst) begin
      if (done) begin
        got.status = status_t'(status);
        got.found_at = found_position;
        got.rec.key_low = out_key_low;
        got.rec.key_high = out_key_high;
        got.rec.score_a = out_score_a;
        got.rec.score_b = out_score_b;
        got.rec.score_c = out_score_c;
        got.length = list_length;
        tracker.check_reply(got);
      end
      if (start && !busy)
        tracker.note_command(cmd_t'(command), position,
                             '{key_low, key_high, score_a, score_b, score_c});
    end
  end

  function automatic rec_t rec_of(logic [63:0] kl, logic [7:0] kh,
                                  logic [7:0] a, logic [7:0] b, logic [7:0] c);
    rec_t r;
    r.key_low = kl;
    r.key_high = kh;
    r.score_a = a;
    r.score_b = b;
    r.score_c = c;
    return r;
  endfunction

  // hold start high until the beat is taken
  task automatic send_command(cmd_t cmd, logic [5:0] pos, rec_t rec);
    command <= cmd;
    position <= pos;
    key_low <= rec.key_low;
    key_high <= rec.key_high;
    score_a <= rec.score_a;
    score_b <= rec.score_b;
    score_c <= rec.score_c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // sender gap: each cycle idles with the given chance
  task automatic hold_off(int pct);
    while (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // name of a record in the list, from the pool, or fully random
  function automatic rec_t pick_name();
    rec_t r;
    int   sel;
    int   k;
    sel = $urandom_range(99);
    k = $urandom_range(7);
    r = rec_of({$urandom, $urandom}, 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
    if (sel < 60 && tracker.count > 0) begin
      k = $urandom_range(tracker.count - 1);
      r.key_low = tracker.cells[k].key_low;
      r.key_high = tracker.cells[k].key_high;
    end else if (sel < 92) begin
      r.key_low = name_low[k];
      r.key_high = name_high[k];
    end
    return r;
  endfunction

  task automatic run_random(int items, int idle_pct);
    int   r;
    int   len;
    cmd_t cmd;
    logic [5:0] pos;
    for (int i = 0; i < items; i++) begin
      hold_off(idle_pct);
      len = tracker.count;
      // sweep between an empty and a full list
      if (len == 0) shrinking = 1'b0;
      else if (len >= CAPACITY && $urandom_range(3) == 0) shrinking = 1'b1;
      r = $urandom_range(99);
      if (r < (shrinking ? 15 : 50)) cmd = CMD_INSERT;
      else if (r < (shrinking ? 35 : 70)) cmd = CMD_READ;
      else if (r < (shrinking ? 50 : 85)) cmd = CMD_FIND;
      else cmd = CMD_DELETE;
      if ($urandom_range(99) < 20) pos = 6'($urandom);
      else if (cmd == CMD_INSERT) pos = 6'($urandom_range(len + 1, 1));
      else pos = 6'($urandom_range(len > 0 ? len : 1, 1));
      send_command(cmd, pos, pick_name());
    end
  endtask

  // run limit
  initial begin
    #2400000;
    $display("keyed_record_list_engine test failed");
    $finish;
  end

  initial begin
    rec_t ones;
    rec_t zero;
    rec_t name_a;
    rec_t name_b;
    rec_t near_a;
    int   idle_pct[4];
    for (int k = 0; k < 8; k++) begin
      name_low[k] = (k % 2 == 1) ? name_low[k - 1] : {$urandom, $urandom};
      name_high[k] = 8'($urandom);
    end
    ones = rec_of('1, '1, '1, '1, '1);
    zero = rec_of('0, '0, '0, '0, '0);
    name_a = rec_of(64'h4e_4f_52_41_4d_41_4e_41, 8'h31, 8'd90, 8'd75, 8'd60);
    name_b = rec_of(64'h53_45_54_55_4c_41_56_45, 8'h00, 8'd12, 8'd200, 8'd7);
    near_a = name_a;
    near_a.key_high = 8'h32;
    idle_pct = '{0, 45, 0, 14};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, bad positions, front/middle/append inserts
    send_command(CMD_READ, 6'd1, zero);
    send_command(CMD_FIND, 6'd0, zero);
    send_command(CMD_DELETE, 6'd0, zero);
    send_command(CMD_INSERT, 6'd0, name_a);
    send_command(CMD_INSERT, 6'd2, name_a);
    send_command(CMD_INSERT, 6'd1, ones);
    send_command(CMD_INSERT, 6'd2, zero);
    send_command(CMD_INSERT, 6'd1, name_a);
    send_command(CMD_INSERT, 6'd2, name_b);
    send_command(CMD_INSERT, 6'd63, name_b);
    send_command(CMD_INSERT, 6'd5, name_a);
    // directed: reads at and beyond the ends
    send_command(CMD_READ, 6'd0, ones);
    send_command(CMD_READ, 6'd1, zero);
    send_command(CMD_READ, 6'd5, zero);
    send_command(CMD_READ, 6'd6, zero);
    send_command(CMD_READ, 6'd63, zero);
    // directed: first match wins, ninth byte counts, gap closes on delete
    send_command(CMD_FIND, 6'd63, name_a);
    send_command(CMD_FIND, 6'd0, near_a);
    send_command(CMD_FIND, 6'd0, ones);
    send_command(CMD_DELETE, 6'd9, name_a);
    send_command(CMD_FIND, 6'd0, name_a);
    send_command(CMD_DELETE, 6'd0, zero);
    send_command(CMD_DELETE, 6'd0, near_a);

    // random phases with different sender gaps
    foreach (idle_pct[p]) run_random(432, idle_pct[p]);
    start <= 1'b0;

    // drain, then wait for anything stray
    for (int w = 0; w < 200 && tracker.pending_replies.size() != 0; w++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    tracker.close_out();

    $display("commands: %0d insert, %0d read, %0d find, %0d delete; list peaked at %0d",
             tracker.cmd_seen[CMD_INSERT], tracker.cmd_seen[CMD_READ],
             tracker.cmd_seen[CMD_FIND], tracker.cmd_seen[CMD_DELETE],
             tracker.peak_length);
    $display("outcomes: %0d ok, %0d not found, %0d out of range, %0d full",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_NOT_FOUND],
             tracker.status_seen[ST_RANGE], tracker.status_seen[ST_FULL]);
    if (tracker.errors == 0) begin
      $display("keyed_record_list_engine test passed");
    end else begin
      $display("keyed_record_list_engine test failed");
    end
    $finish;
  end

endmodule
